// ===== hdl/pff_pkg.sv =====
package pff_pkg;

    localparam int FRAC_W     = 10;
    localparam int LEVEL_W    = 24;
    localparam int CH_W       = 8;
    localparam int MS_W       = 12;
    localparam int DUR_W      = 16;
    localparam int MODE_W     = 3;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUO_W      = MS_W + FRAC_W;

    localparam logic [FUNC_W-1:0] FUNC_COLOUR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_WHITE_IN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FADE_IN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WHITE_OUT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FADE_OUT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLASH     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BLUE  = 3'd4;

    localparam logic [DUR_W-1:0] DURATION_RESET = 16'd1000;

    localparam logic signed [LEVEL_W-1:0] LEVEL_ONE        = 24'sd1024;
    localparam logic signed [LEVEL_W-1:0] LEVEL_START_HIGH = 24'sd1536;
    localparam logic signed [LEVEL_W-1:0] LEVEL_START_FOUT = -24'sd3072;
    localparam logic signed [LEVEL_W-1:0] LEVEL_START_FLSH = -24'sd1024;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX        = 24'sh7FFFFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN        = 24'sh800000;

    typedef enum logic [1:0] {
        OP_COLOUR  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CH_W-1:0]   in_red;
        logic [CH_W-1:0]   in_green;
        logic [CH_W-1:0]   in_blue;
        logic [MS_W-1:0]   frame_ms;
    } pff_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } pff_out_t;

    typedef struct packed {
        op_t             op;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [MS_W-1:0] frame_ms;
    } pff_op_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DUR_W-1:0]  duration_ms;
        logic [CH_W-1:0]   flash_red;
        logic [CH_W-1:0]   flash_green;
        logic [CH_W-1:0]   flash_blue;
    } pff_cfg_t;

    typedef struct packed {
        logic                      busy;
        logic signed [LEVEL_W-1:0] level;
    } pff_status_t;

endpackage

// ===== hdl/palette_fade_flash_unit.sv =====
// Palette fade and flash unit. Items enter a small queue as soon as they are
// classified; a colour entry then passes through the back end (operand
// set-up, one 9x24 multiply per channel, blend and clamp into the output
// register) and waits there while the output register stays stalled. An
// advance item goes through the restoring divider that forms the frame
// step one quotient bit per cycle over 22 bits; a restart reloads the level.
// Items with function code 3 are dropped at the front. The queue holds
// QUEUE_DEPTH items; input flows during an advance until the queue is full.
module palette_fade_flash_unit
    import pff_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pff_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pff_out_t              out_item
);

    pff_cfg_t    cfg_reg, cfg_next;
    logic        q_push;
    pff_op_t     q_push_op;
    logic        q_pop;
    logic        q_valid;
    pff_op_t     q_head;
    logic        q_full;
    pff_status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:        cfg_next.mode        = cfg_data[MODE_W-1:0];
                CFG_DURATION:    cfg_next.duration_ms = cfg_data[DUR_W-1:0];
                CFG_FLASH_RED:   cfg_next.flash_red   = cfg_data[CH_W-1:0];
                CFG_FLASH_GREEN: cfg_next.flash_green = cfg_data[CH_W-1:0];
                CFG_FLASH_BLUE:  cfg_next.flash_blue  = cfg_data[CH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_WHITE_IN;
            cfg_reg.duration_ms <= DURATION_RESET;
            cfg_reg.flash_red   <= '0;
            cfg_reg.flash_green <= '0;
            cfg_reg.flash_blue  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pff_front u_front (
        .in_item  (in_item),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (q_push),
        .push_op  (q_push_op)
    );

    pff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head),
        .full    (q_full)
    );

    pff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .status    (status)
    );

    a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.func == FUNC_NONE) |-> !q_push)
        else $error("function code 3 entered the queue");

    a_level_owner: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(status.level) |-> $past(status.busy))
        else $error("level moved with the back end idle");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.busy))
        else $error("result appeared without back-end work");

endmodule

// ===== hdl/pff_front.sv =====
module pff_front
    import pff_pkg::*;
(
    input  pff_in_t in_item,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    q_full,
    output logic    push,
    output pff_op_t push_op
);

    op_t op;

    always_comb
    begin
        case (in_item.func)
            FUNC_ADVANCE: op = OP_ADVANCE;
            FUNC_RESTART: op = OP_RESTART;
            default:      op = OP_COLOUR;
        endcase
    end

    assign in_stall = q_full;

    // drop items whose function means nothing
    assign push = in_valid && !q_full && (in_item.func != FUNC_NONE);

    assign push_op.op       = op;
    assign push_op.red      = in_item.in_red;
    assign push_op.green    = in_item.in_green;
    assign push_op.blue     = in_item.in_blue;
    assign push_op.frame_ms = in_item.frame_ms;

endmodule

// ===== hdl/pff_queue.sv =====
module pff_queue
    import pff_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  pff_op_t push_op,
    input  logic    pop,
    output logic    valid,
    output pff_op_t head,
    output logic    full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pff_op_t          mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pff_back.sv =====
module pff_back
    import pff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pff_cfg_t    cfg,
    input  logic        q_valid,
    input  pff_op_t     q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output pff_out_t    out_item,
    output pff_status_t status
);

    localparam int CNT_W = $clog2(QUO_W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FIN  = 5'b00100,
        S_DIV  = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        K_PASS  = 3'd0,
        K_SAT   = 3'd1,
        K_ZERO  = 3'd2,
        K_WHITE = 3'd3,
        K_FADE  = 3'd4,
        K_FLASH = 3'd5
    } kind_t;

    function automatic logic signed [LEVEL_W-1:0] start_level(input logic [MODE_W-1:0] m);
        logic signed [LEVEL_W-1:0] v;
        case (m)
            MODE_WHITE_IN:  v = LEVEL_START_HIGH;
            MODE_FADE_IN:   v = LEVEL_START_HIGH;
            MODE_WHITE_OUT: v = '0;
            MODE_FADE_OUT:  v = LEVEL_START_FOUT;
            MODE_FLASH:     v = LEVEL_START_FLSH;
            default:        v = '0;
        endcase
        return v;
    endfunction

    state_t                    state_reg, state_next;
    logic signed [LEVEL_W-1:0] level_reg, level_next;
    kind_t                     kind_reg, kind_next;
    logic [LEVEL_W-1:0]        k_reg, k_next;
    logic [CH_W-1:0]           col_reg [3];
    logic [CH_W-1:0]           col_next [3];
    logic signed [33:0]        prod_reg [3];
    logic signed [33:0]        prod_next [3];
    logic [DUR_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [DUR_W-1:0]          den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    pff_out_t                  out_item_reg, out_item_next;

    logic [CH_W-1:0]           tgt [3];
    logic [CH_W-1:0]           head_col [3];
    kind_t                     kind_cls;
    logic [LEVEL_W-1:0]        k_cls;
    logic [LEVEL_W-1:0]        abs_level;
    logic signed [LEVEL_W-1:0] weight;
    logic signed [8:0]         diff [3];
    logic [CH_W-1:0]           res [3];
    logic signed [34:0]        flash_sum [3];
    logic [DUR_W:0]            shifted;
    logic                      ge;
    logic signed [LEVEL_W:0]   level_sum;
    logic                      level_upd;
    logic signed [LEVEL_W-1:0] level_sat;

    assign tgt[0]      = cfg.flash_red;
    assign tgt[1]      = cfg.flash_green;
    assign tgt[2]      = cfg.flash_blue;
    assign head_col[0] = q_head.red;
    assign head_col[1] = q_head.green;
    assign head_col[2] = q_head.blue;

    assign weight    = LEVEL_ONE - level_reg;
    assign abs_level = level_reg[LEVEL_W-1] ? LEVEL_W'(-level_reg) : LEVEL_W'(level_reg);

    always_comb
    begin
        kind_cls = K_PASS;
        k_cls    = LEVEL_W'(weight);
        case (cfg.mode)
            MODE_WHITE_IN, MODE_WHITE_OUT:
            begin
                if (level_reg > LEVEL_ONE)
                    kind_cls = K_SAT;
                else if (level_reg > 24'sd0)
                    kind_cls = K_WHITE;
            end
            MODE_FADE_IN, MODE_FADE_OUT:
            begin
                if (level_reg > LEVEL_ONE)
                    kind_cls = K_ZERO;
                else if (level_reg > 24'sd0)
                    kind_cls = K_FADE;
            end
            MODE_FLASH:
            begin
                if (level_reg < LEVEL_ONE)
                begin
                    kind_cls = K_FLASH;
                    k_cls    = abs_level;
                end
            end
            default:
            begin
                kind_cls = K_PASS;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (kind_reg)
                K_WHITE: diff[i] = $signed({1'b0, 8'd255 - col_reg[i]});
                K_FLASH: diff[i] = $signed({1'b0, col_reg[i]}) - $signed({1'b0, tgt[i]});
                default: diff[i] = $signed({1'b0, col_reg[i]});
            endcase
            prod_next[i] = diff[i] * $signed({1'b0, k_reg});

            flash_sum[i] = $signed({prod_reg[i][33], prod_reg[i]})
                         + $signed({17'b0, tgt[i], 10'b0});
            case (kind_reg)
                K_SAT:   res[i] = 8'd255;
                K_ZERO:  res[i] = 8'd0;
                K_WHITE: res[i] = 8'd255 - prod_reg[i][17:10];
                K_FADE:  res[i] = prod_reg[i][17:10];
                K_FLASH:
                begin
                    if (flash_sum[i][34])
                        res[i] = 8'd0;
                    else if (|flash_sum[i][33:18])
                        res[i] = 8'd255;
                    else
                        res[i] = flash_sum[i][17:10];
                end
                default: res[i] = col_reg[i];
            endcase
        end
    end

    // one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        level_upd = 1'b0;
        level_sum = {level_reg[LEVEL_W-1], level_reg};
        case (cfg.mode)
            MODE_WHITE_IN, MODE_FADE_IN:
            begin
                if (level_reg > 24'sd0)
                begin
                    level_upd = 1'b1;
                    level_sum = {level_reg[LEVEL_W-1], level_reg}
                              - $signed({3'b0, quo_reg});
                end
            end
            MODE_WHITE_OUT, MODE_FADE_OUT:
            begin
                if (level_reg <= LEVEL_ONE)
                begin
                    level_upd = 1'b1;
                    level_sum = {level_reg[LEVEL_W-1], level_reg}
                              + $signed({3'b0, quo_reg});
                end
            end
            MODE_FLASH:
            begin
                if (level_reg < LEVEL_ONE)
                begin
                    level_upd = 1'b1;
                    level_sum = {level_reg[LEVEL_W-1], level_reg}
                              + $signed({3'b0, quo_reg});
                end
            end
            default:
            begin
                level_upd = 1'b0;
            end
        endcase
        if (level_sum[LEVEL_W] != level_sum[LEVEL_W-1])
            level_sat = level_sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
        else
            level_sat = level_sum[LEVEL_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        kind_next      = kind_reg;
        k_next         = k_reg;
        col_next       = col_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    case (q_head.op)
                        OP_COLOUR:
                        begin
                            kind_next  = kind_cls;
                            k_next     = k_cls;
                            col_next   = head_col;
                            state_next = S_MUL;
                        end
                        OP_ADVANCE:
                        begin
                            rem_next   = '0;
                            quo_next   = {q_head.frame_ms, {FRAC_W{1'b0}}};
                            den_next   = (cfg.duration_ms == '0) ? DUR_W'(1) : cfg.duration_ms;
                            cnt_next   = CNT_W'(QUO_W - 1);
                            state_next = S_DIV;
                        end
                        OP_RESTART:
                        begin
                            level_next = start_level(cfg.mode);
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.out_red   = res[0];
                    out_item_next.out_green = res[1];
                    out_item_next.out_blue  = res[2];
                    state_next              = S_IDLE;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? DUR_W'(shifted - {1'b0, den_reg}) : DUR_W'(shifted);
                quo_next = {quo_reg[QUO_W-2:0], ge};
                if (cnt_reg == '0)
                    state_next = S_UPD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_UPD:
            begin
                if (level_upd)
                    level_next = level_sat;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        k_reg        <= k_next;
        col_reg      <= col_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        out_item_reg <= out_item_next;
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= LEVEL_START_HIGH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_item     = out_item_reg;
    assign status.busy  = (state_reg != S_IDLE) || pop;
    assign status.level = level_reg;

endmodule
